/* src/fbpa_pkg.sv */
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ELEMENT_SIZE = 2'd1;
  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd2;

  // reset values of the registers
  localparam logic [31:0] BASE_ADDRESS_RST = 32'd0;
  localparam logic [15:0] ELEMENT_SIZE_RST = 16'd64;
  localparam logic [10:0] SLOTS_IN_USE_RST = 11'd1024;

  // request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [9:0]  slot_to_free;
    logic [15:0] request_size;
  } in_t;

  typedef struct packed {
    logic [9:0]  slot_given;
    logic [31:0] slot_address;
    status_t     status;
  } out_t;

endpackage

/* src/fbpa_link_ram.sv */
// link memory of the free list: one write port, one registered read port
module fbpa_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/fixed_block_pool_allocator.sv */
// top level of the fixed block pool allocator
//
// Hands out and takes back equal-sized slots of a pool kept as a lifo free
// list. An allocate beat returns the slot index and its byte address
// (base_address + slot * element_size, modulo 2^32); a free beat pushes the
// slot back. Every beat gives exactly one result beat with a status: ok, pool
// empty, size too large, or index out of range. After reset and after any
// register write the pool holds slots 0..n-1: freed slots go out first, then
// never-used slots in ascending order, so no clearing pass is needed and the
// block is ready right after reset. Throughput is one beat per cycle, pops
// and pushes in any mix, and the result is registered; the only limit is the
// single output register, which holds the input off while its result is
// stalled. The link of the head slot is kept in a register and refilled from
// the link memory's registered read port on every pop, so back-to-back pops
// need no wait. Registers must be written only while the block is idle.
module fixed_block_pool_allocator #(
  parameter int SLOTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fbpa_pkg::in_t                    in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output fbpa_pkg::out_t                   out_data,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fbpa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // slot index width, link width (one more code for the null link)
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  // common width for count compares
  localparam int CMP_W  = (LINK_W > 11) ? LINK_W : 11;
  localparam int PROD_W = IDX_W + 16;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

  // configuration registers
  logic [31:0] base_address_r;
  logic [15:0] element_size_r;
  logic [10:0] slots_in_use_r;

  // free list state
  logic [LINK_W-1:0] head_r,  head_nxt;    // head of recycled list
  logic [LINK_W-1:0] hlink_r, hlink_nxt;   // link of head when not pending
  logic              pend_r,  pend_nxt;    // head link sits in ram read data
  logic [LINK_W-1:0] fresh_r, fresh_nxt;   // never-used slots handed out

  // output register
  logic              out_valid_r, out_valid_nxt;
  fbpa_pkg::out_t    out_data_r,  out_data_nxt;

  logic              in_accept;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  logic [LINK_W-1:0] hlink_eff;
  logic [LINK_W-1:0] ram_rdata;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;

  logic [CMP_W-1:0]  slots_ext;
  logic [CMP_W-1:0]  count;
  logic [CMP_W-1:0]  fresh_ext;
  logic [CMP_W-1:0]  free_ext;
  logic              too_large;
  logic              has_recycled;
  logic              has_fresh;
  logic              free_ok;
  logic [IDX_W-1:0]  given;
  logic [PROD_W-1:0] offset;

  // ---------------------------------------------------------------------
  // configuration port, zero wait states
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_idx)
      fbpa_pkg::REG_BASE_ADDRESS: prdata = base_address_r;
      fbpa_pkg::REG_ELEMENT_SIZE: prdata = 32'(element_size_r);
      fbpa_pkg::REG_SLOTS_IN_USE: prdata = 32'(slots_in_use_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= fbpa_pkg::BASE_ADDRESS_RST;
      element_size_r <= fbpa_pkg::ELEMENT_SIZE_RST;
      slots_in_use_r <= fbpa_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fbpa_pkg::REG_BASE_ADDRESS: base_address_r <= pwdata;
        fbpa_pkg::REG_ELEMENT_SIZE: element_size_r <= pwdata[15:0];
        fbpa_pkg::REG_SLOTS_IN_USE: slots_in_use_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: stall only while the held result is itself stalled
  // ---------------------------------------------------------------------
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  // right after a pop the new head's link arrives on the ram read port
  assign hlink_eff = pend_r ? ram_rdata : hlink_r;

  // effective slot count, capped at the pool depth
  assign slots_ext = CMP_W'(slots_in_use_r);
  assign count     = (slots_ext < CMP_W'(SLOTS)) ? slots_ext : CMP_W'(SLOTS);
  assign fresh_ext = CMP_W'(fresh_r);
  assign free_ext  = CMP_W'(in_data.slot_to_free);

  assign too_large    = in_data.request_size > element_size_r;
  assign has_recycled = head_r != NULL_LINK;
  assign has_fresh    = fresh_ext < count;
  assign free_ok      = free_ext < count;

  assign given  = has_recycled ? head_r[IDX_W-1:0] : fresh_r[IDX_W-1:0];
  assign offset = PROD_W'(given) * PROD_W'(element_size_r);

  always_comb begin
    head_nxt      = head_r;
    hlink_nxt     = hlink_eff;
    pend_nxt      = 1'b0;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = free_ext[IDX_W-1:0];
    ram_re        = 1'b0;
    ram_raddr     = hlink_eff[IDX_W-1:0];

    if (cfg_wr && cfg_idx inside {fbpa_pkg::REG_BASE_ADDRESS, fbpa_pkg::REG_ELEMENT_SIZE,
                                  fbpa_pkg::REG_SLOTS_IN_USE}) begin
      // any register write restarts the pool
      head_nxt  = NULL_LINK;
      fresh_nxt = '0;
    end else if (in_accept) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.slot_given   = '0;
      out_data_nxt.slot_address = '0;
      if (in_data.mode == fbpa_pkg::MODE_ALLOC) begin
        if (too_large) begin
          out_data_nxt.status = fbpa_pkg::ST_TOO_LARGE;
        end else if (has_recycled || has_fresh) begin
          out_data_nxt.status       = fbpa_pkg::ST_OK;
          out_data_nxt.slot_given   = 10'(given);
          out_data_nxt.slot_address = base_address_r + 32'(offset);
          if (has_recycled) begin
            // pop: fetch the link of the new head for the next beat
            head_nxt = hlink_eff;
            ram_re   = hlink_eff != NULL_LINK;
            pend_nxt = ram_re;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
        end else begin
          out_data_nxt.status = fbpa_pkg::ST_EMPTY;
        end
      end else begin
        if (free_ok) begin
          out_data_nxt.status = fbpa_pkg::ST_OK;
          // push: freed slot links to the old head
          ram_we    = 1'b1;
          head_nxt  = free_ext[LINK_W-1:0];
          hlink_nxt = head_r;
        end else begin
          out_data_nxt.status = fbpa_pkg::ST_RANGE;
        end
      end
    end
  end

  fbpa_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_LINK;
      pend_r      <= 1'b0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hlink_r    <= hlink_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a pending head link only follows an accepted pop
  a_pend_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(in_accept) && $past(in_data.mode) == fbpa_pkg::MODE_ALLOC)
    else $error("link prefetch pending without a pop");

  // never more fresh slots handed out than the pool holds
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NULL_LINK)
    else $error("fresh count beyond pool depth");

  // a new result comes only from an accepted beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept))
    else $error("result without a request");

  // failed or free results carry no slot
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != fbpa_pkg::ST_OK
      |-> out_data_r.slot_given == '0 && out_data_r.slot_address == '0)
    else $error("failed request returned a slot");

  // the link ram is never written and read on the same edge
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("link ram push and pop together");
`endif

endmodule

/* test/fbpa_pool_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the pool allocator: mirrors the free list and checks every result beat
module fbpa_pool_checker
  import fbpa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_t                    in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_t                   out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output int unsigned            outstanding,
  output int unsigned            mismatches
);

  localparam int POOL_SLOTS = 1024;
  localparam logic [10:0] NO_SLOT = 11'(POOL_SLOTS);

  // shadow registers
  logic [31:0] base_q;
  logic [15:0] elem_q;
  logic [10:0] slots_q;

  // shadow free list
  logic [10:0] recycle_head;
  logic [10:0] link_mem [POOL_SLOTS];
  logic [10:0] fresh_used;

  out_t        results_due [$];
  int unsigned errs = 0;
  logic        reg_hit;

  // one request against the shadow pool, returns the result beat it must cause
  function automatic out_t serve_request(in_t req);
    out_t        res;
    logic [10:0] avail;
    res.slot_given   = '0;
    res.slot_address = '0;
    res.status       = ST_OK;
    avail = (slots_q < NO_SLOT) ? slots_q : NO_SLOT;
    if (req.mode == MODE_ALLOC) begin
      if (req.request_size > elem_q) begin
        res.status = ST_TOO_LARGE;
      end else if (recycle_head < NO_SLOT) begin
        res.slot_given = recycle_head[9:0];
        recycle_head   = link_mem[recycle_head[9:0]];
      end else if (fresh_used < avail) begin
        res.slot_given = fresh_used[9:0];
        fresh_used     = fresh_used + 11'd1;
      end else begin
        res.status = ST_EMPTY;
      end
      if (res.status == ST_OK)
        res.slot_address = base_q + 32'(res.slot_given) * 32'(elem_q);
    end else if ({1'b0, req.slot_to_free} >= avail) begin
      res.status = ST_RANGE;
    end else begin
      link_mem[req.slot_to_free] = recycle_head;
      recycle_head = {1'b0, req.slot_to_free};
    end
    return res;
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      $error("result beat with nothing expected: slot_given %0d slot_address %h status %0d",
             got.slot_given, got.slot_address, got.status);
      errs++;
    end else begin
      want = results_due.pop_front();
      if (got.slot_given !== want.slot_given) begin
        $error("slot_given: expected %0d, got %0d", want.slot_given, got.slot_given);
        errs++;
      end
      if (got.slot_address !== want.slot_address) begin
        $error("slot_address: expected %h, got %h", want.slot_address, got.slot_address);
        errs++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      base_q       = BASE_ADDRESS_RST;
      elem_q       = ELEMENT_SIZE_RST;
      slots_q      = SLOTS_IN_USE_RST;
      recycle_head = NO_SLOT;
      fresh_used   = '0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_hit = 1'b1;
        case (paddr[3:2])
          REG_BASE_ADDRESS: base_q  = pwdata;
          REG_ELEMENT_SIZE: elem_q  = pwdata[15:0];
          REG_SLOTS_IN_USE: slots_q = pwdata[10:0];
          default:          reg_hit = 1'b0;
        endcase
        // any register write restarts the pool
        if (reg_hit) begin
          recycle_head = NO_SLOT;
          fresh_used   = '0;
        end
      end
      // retire before queuing, a request never comes out in the beat it goes in
      if (out_valid && !out_stall)
        check_result(out_data);
      if (in_valid && !in_stall)
        results_due.push_back(serve_request(in_data));
    end
    outstanding <= results_due.size();
    mismatches  <= errs;
  end

endmodule

/* test/tb_fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps
// testbench top of the pool allocator: stimulus, idle bursts, watchdog and verdict
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int unsigned outstanding;
  int unsigned mismatches;

  // idle shaping, percent chance per beat of starting an idle burst
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;

  int sent = 0;
  int directed_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_block_pool_allocator #(
    .SLOTS(1024)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  fbpa_pool_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any accepted beat on either channel or register access counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat; valid stays up through the stall, then maybe a gap
  task automatic push_request(input logic m, input logic [9:0] slot, input logic [15:0] size);
    in_t beat;
    int  gap;
    beat.mode         = m;
    beat.slot_to_free = slot;
    beat.request_size = size;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the request side off until every result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // setup then access; psel stays up between back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // pick selects which registers get written, never zero
  task automatic load_registers(input logic [31:0] base, input logic [15:0] elem,
                                input logic [10:0] slots, input logic [2:0] pick);
    if (pick[0]) write_reg(REG_BASE_ADDRESS, base);
    if (pick[1]) write_reg(REG_ELEMENT_SIZE, {16'd0, elem});
    if (pick[2]) write_reg(REG_SLOTS_IN_USE, {21'd0, slots});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] base;
    logic [15:0] elem;
    logic [10:0] slots;
    logic [2:0]  pick;
    logic [9:0]  slot;
    logic [15:0] size;
    logic        m;
    int          usable;
    int          alloc_pct;
    int          fill_pct;
    int          roll;
    bit          final_phase;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, mild idling on both sides
    gap_pct   = 20;
    stall_pct <= 20;

    // reset values: base 0, 64 byte slots, full 1024 slot pool
    push_request(MODE_ALLOC, 10'd0, 16'd0);       // smallest size
    push_request(MODE_ALLOC, 10'd0, 16'd64);      // size equal to slot size
    push_request(MODE_ALLOC, 10'd0, 16'd65);      // one byte too many
    push_request(MODE_ALLOC, 10'h3FF, 16'hFFFF);  // largest size
    push_request(MODE_FREE, 10'd1023, 16'hFFFF);  // free of a never-used top slot
    push_request(MODE_FREE, 10'd0, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd1);       // lifo: slot 0 comes back first
    push_request(MODE_ALLOC, 10'd0, 16'd10);      // then slot 1023
    push_request(MODE_FREE, 10'd5, 16'd0);
    push_request(MODE_FREE, 10'd5, 16'd0);        // double free goes through
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd0);       // same slot handed out twice
    push_request(MODE_ALLOC, 10'd0, 16'd0);       // slot 5 yet again, its link points to itself
    settle();

    // zero slot size, two slot pool near the top of the address space
    load_registers(32'hFFFF_FF00, 16'd0, 11'd2, 3'b111);
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd1);       // too large wins over empty
    push_request(MODE_ALLOC, 10'd0, 16'd0);       // pool empty
    push_request(MODE_FREE, 10'd2, 16'd0);        // index just past the pool
    push_request(MODE_FREE, 10'd1023, 16'd0);
    push_request(MODE_FREE, 10'd1, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    settle();

    // zero slot count: always empty, every free out of range
    load_registers(32'd0, 16'd0, 11'd0, 3'b100);
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    push_request(MODE_FREE, 10'd0, 16'd0);
    settle();

    // widest settings, slot count above the pool gets capped
    load_registers(32'hFFFF_FFFF, 16'hFFFF, 11'd2047, 3'b111);
    push_request(MODE_ALLOC, 10'd0, 16'hFFFF);
    push_request(MODE_ALLOC, 10'd0, 16'hFFFF);    // address wraps past 2^32
    push_request(MODE_FREE, 10'd1023, 16'd0);
    push_request(MODE_ALLOC, 10'd0, 16'd0);
    settle();
    directed_sent = sent;

    // random part: each phase works a freshly configured pool, one alloc mix then the opposite
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      final_phase = (ph == RANDOM_PHASES - 1);

      case ($urandom_range(0, 3))
        0:       base = 32'd0;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       elem = 16'd0;
        1:       elem = 16'd1;
        2:       elem = 16'hFFFF;
        default: elem = 16'($urandom_range(2, 512));
      endcase
      // small pools most of the time so that empty and recycling get exercised
      case ($urandom_range(0, 4))
        0:       slots = 11'($urandom_range(1, 4));
        1:       slots = 11'($urandom_range(5, 40));
        2:       slots = 11'd1024;
        3:       slots = 11'($urandom_range(1025, 2047));
        default: slots = 11'($urandom_range(41, 300));
      endcase
      pick = 3'($urandom_range(1, 7));
      load_registers(base, elem, slots, pick);
      // what the block now holds, whatever was written
      if (pick[1] == 1'b0) elem = 'x;
      usable = -1;

      // idling level for this phase; the closing phase runs flat out
      if (final_phase) begin
        gap_pct   = 0;
        stall_pct <= 0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin gap_pct = 0;  stall_pct <= 0;  end
          1: begin gap_pct = 20; stall_pct <= 20; end
          2: begin gap_pct = 50; stall_pct <= 50; end
          default: begin gap_pct = 10; stall_pct <= 60; end
        endcase
      end

      case ($urandom_range(0, 3))
        0:       alloc_pct = 35;
        1:       alloc_pct = 60;
        2:       alloc_pct = 80;
        default: alloc_pct = 95;
      endcase

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        fill_pct = (k < ITEMS_PER_PHASE / 2) ? alloc_pct : 100 - alloc_pct;
        m = ($urandom_range(0, 99) < fill_pct) ? MODE_ALLOC : MODE_FREE;
        // unused field of each beat carries random bits
        slot = 10'($urandom_range(0, 1023));
        size = 16'($urandom_range(0, 65535));
        if (m == MODE_ALLOC) begin
          roll = $urandom_range(0, 99);
          if ($isunknown(elem))
            size = (roll < 80) ? 16'($urandom_range(0, 64)) : size;
          else if (roll < 80)
            size = 16'($urandom_range(0, elem));
          else if (roll < 90)
            size = (elem == 16'hFFFF) ? elem : elem + 16'd1;
        end else begin
          // mostly slots inside the pool, the rest anywhere
          if (usable < 0) usable = 1024;
          if (pick[2]) usable = (slots > 11'd1024) ? 1024 : int'(slots);
          if (usable != 0 && $urandom_range(0, 99) < 85)
            slot = 10'($urandom_range(0, usable - 1));
        end
        push_request(m, slot, size);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d requests (%0d directed) over %0d register settings,",
             sent, directed_sent, settings_used);
    $display("with random idle bursts on both channels and a closing stretch without any");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* fixed_block_pool_allocator.f */
src/fbpa_pkg.sv
src/fbpa_link_ram.sv
src/fixed_block_pool_allocator.sv
test/fbpa_pool_checker.sv
test/tb_fixed_block_pool_allocator.sv
